// File: hdl/ygts_pkg.sv
package ygts_pkg;

   localparam int YAW_W    = 16;
   localparam int CMD_W    = 16;
   localparam int TOL_W    = 15;
   localparam int ALPHA_W  = 17;
   localparam int THR_W    = 15;
   localparam int CSR_IDX_W = 2;

   localparam int MCAND_W  = 17;
   localparam int MPLIER_W = 16;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int DVD_W    = 31;
   localparam int DVS_W    = 15;
   localparam int QUO_W    = 16;
   localparam int SUM_W    = PROD_W + 2;

   localparam logic [TOL_W-1:0]   OUTER_RESET = 15'd5719;
   localparam logic [TOL_W-1:0]   INNER_RESET = 15'd1430;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
   localparam logic [THR_W-1:0]   THRUST_MAX  = 15'd25600;

   localparam logic [CSR_IDX_W-1:0] REG_OUTER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 2'd2;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hdl/ygts_if.sv
interface ygts_req_if import ygts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [YAW_W-1:0] yaw_error;
   logic signed [CMD_W-1:0] rudder_cmd;
   logic signed [CMD_W-1:0] thrust_cmd;

   modport source (output valid, output yaw_error, output rudder_cmd, output thrust_cmd,
                   input ready);
   modport sink (input valid, input yaw_error, input rudder_cmd, input thrust_cmd,
                 output ready);
endinterface

interface ygts_rsp_if import ygts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] rudder_out;
   logic [THR_W-1:0]        thrust_out;

   modport source (output valid, output rudder_out, output thrust_out, input ready);
   modport sink (input valid, input rudder_out, input thrust_out, output ready);
endinterface

// File: hdl/ygts_mul.sv
module ygts_mul import ygts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam int CNT_W = $clog2(MPLIER_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [MCAND_W-1:0]  mcand_ff;
   logic [MCAND_W-1:0]  hi_ff;
   logic [MPLIER_W-1:0] lo_ff;
   logic [MCAND_W:0]    sum_in;

   // One multiplier bit per cycle: add the multiplicand when the low bit is set, then shift.
   always_comb begin
      sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : {(MCAND_W + 1){1'b0}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(MPLIER_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         mcand_ff <= req.mcand;
         hi_ff    <= '0;
         lo_ff    <= req.mplier;
      end else if (busy_ff) begin
         hi_ff <= sum_in[MCAND_W:1];
         lo_ff <= {sum_in[0], lo_ff[MPLIER_W-1:1]};
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = {hi_ff, lo_ff};

endmodule

// File: hdl/ygts_div.sv
module ygts_div import ygts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVD_W-1:0] dq_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DVS_W-1:0] rem_in;

   // Restoring division, one quotient bit per cycle, dividend bits shifted in from the top.
   always_comb begin
      trial  = {rem_ff, dq_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvs_ff <= req.divisor;
         rem_ff <= '0;
         dq_ff  <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[DVD_W-2:0], fits};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dq_ff[QUO_W-1:0];

endmodule

// File: hdl/yaw_gated_thrust_smoother_top.sv
// Yaw-gated thrust smoother. Each item on req_ch carries a yaw error, a rudder command and
// a thrust request; one result item on rsp_ch returns the rudder unchanged and the gated,
// smoothed thrust, which is also kept as the previous thrust for the next item. Items are
// processed one at a time through a bit-serial shift-add multiplier pair and a restoring
// divider. An item whose yaw error falls in the taper between the tolerances runs a
// multiply, a divide and a second multiply before the sum and round states; any other
// item runs one multiply pass. A new item is accepted while the previous result still
// waits on rsp_ch. Configuration registers are written through csr_wr_en, csr_index and
// csr_data, which the user must do only while no item is in flight; the block has no check.
module yaw_gated_thrust_smoother_top import ygts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ygts_req_if.sink             req_ch,
   ygts_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ALPHA_W-1:0]   csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;
   localparam logic [2:0] ST_RND  = 3'd5;

   localparam logic signed [SUM_W-1:0] LOW_LIMIT = SUM_W'(35'sd16777216);
   localparam logic signed [SUM_W-1:0] HALF_LSB  = SUM_W'(35'sd32768);

   logic [2:0]              state_ff;
   logic [2:0]              state_in;
   logic [TOL_W-1:0]        outer_ff;
   logic [TOL_W-1:0]        inner_ff;
   logic [ALPHA_W-1:0]      alpha_ff;
   logic [THR_W-1:0]        prev_ff;
   logic signed [CMD_W-1:0] rudder_ff;
   logic                    neg_ff;
   logic [TOL_W-1:0]        den_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic                    rsp_valid_ff;
   logic signed [CMD_W-1:0] rsp_rudder_ff;
   logic [THR_W-1:0]        rsp_thrust_ff;

   logic                    accept;
   logic [YAW_W-1:0]        fe;
   logic [CMD_W-1:0]        mag;
   logic                    above;
   logic                    full_band;
   logic                    taper;
   logic [TOL_W-1:0]        diff;
   logic [ALPHA_W-1:0]      a_sat;
   logic [ALPHA_W-1:0]      one_minus_a;
   logic signed [SUM_W-1:0] p1;
   logic signed [SUM_W-1:0] p2;
   logic signed [SUM_W-1:0] rnd;
   logic [SUM_W-17:0]       rnd_hi;
   logic [THR_W-1:0]        res;
   logic                    out_free;
   logic                    load_out;

   mul_req_type mula_req;
   mul_rsp_type mula_rsp;
   mul_req_type mulb_req;
   mul_rsp_type mulb_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   ygts_mul u_mula (.clock(clock), .reset(reset), .req(mula_req), .rsp(mula_rsp));
   ygts_mul u_mulb (.clock(clock), .reset(reset), .req(mulb_req), .rsp(mulb_rsp));
   ygts_div u_div  (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign accept   = (state_ff == ST_IDLE) && req_ch.valid;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_out = (state_ff == ST_RND) && out_free;

   always_comb begin
      fe     = req_ch.yaw_error[YAW_W-1] ? (~req_ch.yaw_error + 1'b1) : req_ch.yaw_error;
      mag    = req_ch.thrust_cmd[CMD_W-1] ? (~req_ch.thrust_cmd + 1'b1) : req_ch.thrust_cmd;
      above  = fe > {1'b0, outer_ff};
      full_band = fe <= {1'b0, inner_ff};
      taper  = !above && !full_band;
      diff   = outer_ff - fe[TOL_W-1:0];
      a_sat  = alpha_ff[ALPHA_W-1] ? ALPHA_ONE : alpha_ff;
      one_minus_a = ALPHA_ONE - a_sat;
   end

   always_comb begin
      mula_req = '0;
      mulb_req = '0;
      div_req  = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mulb_req.start  = 1'b1;
               mulb_req.mcand  = a_sat;
               mulb_req.mplier = {1'b0, prev_ff};
               mula_req.start  = 1'b1;
               if (taper) begin
                  mula_req.mcand  = {1'b0, mag};
                  mula_req.mplier = {1'b0, diff};
                  state_in        = ST_MUL1;
               end else begin
                  mula_req.mcand  = one_minus_a;
                  mula_req.mplier = above ? '0 : mag;
                  state_in        = ST_MUL2;
               end
            end
         end
         ST_MUL1: begin
            if (mula_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = mula_rsp.product[DVD_W-1:0];
               div_req.divisor  = den_ff;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mula_req.start  = 1'b1;
               mula_req.mcand  = one_minus_a;
               mula_req.mplier = div_rsp.quotient;
               state_in        = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mula_rsp.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      p1     = $signed({2'b00, mula_rsp.product});
      p2     = $signed({2'b00, mulb_rsp.product});
      sum_in = neg_ff ? (p2 - p1) : (p2 + p1);
      rnd    = sum_ff + HALF_LSB;
      rnd_hi = rnd[SUM_W-1:16];
      if (sum_ff < LOW_LIMIT) begin
         res = '0;
      end else if (rnd_hi > {{(SUM_W - 16 - THR_W){1'b0}}, THRUST_MAX}) begin
         res = THRUST_MAX;
      end else begin
         res = rnd_hi[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         outer_ff     <= OUTER_RESET;
         inner_ff     <= INNER_RESET;
         alpha_ff     <= ALPHA_RESET;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_OUTER: outer_ff <= csr_data[TOL_W-1:0];
               REG_INNER: inner_ff <= csr_data[TOL_W-1:0];
               REG_ALPHA: alpha_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (load_out) begin
            prev_ff      <= res;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rudder_ff <= req_ch.rudder_cmd;
         neg_ff    <= req_ch.thrust_cmd[CMD_W-1];
         den_ff    <= outer_ff - inner_ff;
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (load_out) begin
         rsp_rudder_ff <= rudder_ff;
         rsp_thrust_ff <= res;
      end
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.rudder_out = rsp_rudder_ff;
   assign rsp_ch.thrust_out = rsp_thrust_ff;

`ifndef SYNTH
   // The stored previous thrust always matches the result item still waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (prev_ff == rsp_thrust_ff))
      else $error("previous thrust differs from pending result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_thrust_ff <= THRUST_MAX))
      else $error("thrust result above saturation limit");

   // An accepted item leaves the idle state until its result is loaded into the output register.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE))
      else $error("block idle right after accepting an item");

   // The second multiplier always finishes before the final blend is summed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL2) |-> !mulb_rsp.done || mula_rsp.done)
      else $error("multiplier finished out of order");
`endif

endmodule
